>>> rtl/core/assert_macros.svh
// assertion macros for the rtl files, used by binary_trie_prefix_match
// no dependencies; each macro samples on the rising edge of clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/btpm_pkg.sv
// shared constants and codes for the binary trie prefix matcher
// no dependencies
package btpm_pkg;

   // default sizes
   localparam int NODES_DEF     = 4096;
   localparam int ADDR_BITS_DEF = 32;

   // bit_count field width
   localparam int CNT_W = 6;

   // command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

>>> rtl/core/btpm_if.sv
// request and response channel interfaces of the trie matcher
// depends on btpm_pkg
interface btpm_req_if #(parameter int ADDR_BITS = btpm_pkg::ADDR_BITS_DEF);
   import btpm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [ADDR_BITS-1:0] address;
   logic [CNT_W-1:0]     bit_count;
   logic                 is_prefix;

   modport source (output valid, cmd, address, bit_count, is_prefix, input ready);
   modport sink   (input valid, cmd, address, bit_count, is_prefix, output ready);
endinterface

interface btpm_rsp_if;
   logic valid;
   logic ready;
   logic match;
   logic status;

   modport source (output valid, match, status, input ready);
   modport sink   (input valid, match, status, output ready);
endinterface

>>> rtl/core/btpm_node_mem.sv
// node pool memory: one write port, one registered read port
// the root entry reads as all zero until it is first written; no dependencies
module btpm_node_mem #(
   parameter int DEPTH  = 4096,
   parameter int WORD_W = 26
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data
);
   localparam int AW = $clog2(DEPTH);

   logic [WORD_W-1:0] node_mem [DEPTH];
   logic [WORD_W-1:0] rd_q_ff;
   logic              root_written_ff;
   logic              root_written_in;
   logic              rd_blank_ff;
   logic              rd_blank_in;

   // storage and read data register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= node_mem[rd_addr];
      end
   end

   // root stays blank until written once
   always_comb begin
      root_written_in = root_written_ff | (wr_en && (wr_addr == AW'(0)));
      rd_blank_in     = rd_en ? ((rd_addr == AW'(0)) && !root_written_ff) : rd_blank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_written_ff <= 1'b0;
         rd_blank_ff     <= 1'b0;
      end else begin
         root_written_ff <= root_written_in;
         rd_blank_ff     <= rd_blank_in;
      end
   end

   assign rd_data = rd_blank_ff ? '0 : rd_q_ff;

endmodule

>>> rtl/core/binary_trie_prefix_match.sv
// Binary trie prefix matcher. A beat on req_chan either looks up an address
// or inserts an exact entry or a wildcard prefix; each beat returns one beat
// on rsp_chan (match for a lookup, status for an insert, the other field 0).
// Nodes live in one single-port-read, single-port-write memory of NODES
// words; every trie level costs a memory read (S_RD) and an evaluate
// (S_EVAL), or an evaluate and a zeroing write (S_ZERO) when an insert
// allocates a node. One item is in flight at a time; the next one is taken
// while the previous response still waits on rsp_chan. No clearing pass
// after reset.
// depends on btpm_pkg, btpm_if, btpm_node_mem and assert_macros.svh
`include "assert_macros.svh"

module binary_trie_prefix_match #(
   parameter int NODES     = btpm_pkg::NODES_DEF,
   parameter int ADDR_BITS = btpm_pkg::ADDR_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   btpm_req_if.sink    req_chan,
   btpm_rsp_if.source  rsp_chan
);
   import btpm_pkg::*;

   localparam int IW     = $clog2(NODES);
   localparam int NW     = $clog2(NODES + 1);
   localparam int CW     = $clog2(ADDR_BITS + 1);
   localparam int WORD_W = 2 * IW + 2;
   // word layout: {child_one, child_zero, subnet, exact}
   localparam int EXACT_B  = 0;
   localparam int SUBNET_B = 1;
   localparam int C0_LO    = 2;
   localparam int C1_LO    = 2 + IW;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD   = 5'b00010,
      S_EVAL = 5'b00100,
      S_ZERO = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 pre_ff, pre_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [IW-1:0]        node_ff, node_in;
   logic                 zero_ff, zero_in;
   logic [NW-1:0]        nf_ff, nf_in;
   logic                 res_match_ff, res_match_in;
   logic                 res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_match_ff, rsp_match_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 mem_rd_en;
   logic [WORD_W-1:0]    mem_rd_data;
   logic                 mem_wr_en;
   logic [IW-1:0]        mem_wr_addr;
   logic [WORD_W-1:0]    mem_wr_data;

   logic                 req_beat;
   logic                 out_free;

   btpm_node_mem #(
      .DEPTH  (NODES),
      .WORD_W (WORD_W)
   ) u_node_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (node_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // walk sequencer: read node, evaluate, descend or allocate
   always_comb begin
      logic [WORD_W-1:0] word;
      logic              bit_now;
      logic [IW-1:0]     child;
      logic [WORD_W-1:0] upd;

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      pre_in        = pre_ff;
      rem_in        = rem_ff;
      node_in       = node_ff;
      zero_in       = zero_ff;
      nf_in         = nf_ff;
      res_match_in  = res_match_ff;
      res_status_in = res_status_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = '0;

      word    = zero_ff ? '0 : mem_rd_data;
      bit_now = addr_ff[ADDR_BITS-1];
      child   = bit_now ? word[C1_LO +: IW] : word[C0_LO +: IW];
      upd     = word;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               cmd_in  = req_chan.cmd;
               addr_in = req_chan.address;
               pre_in  = req_chan.is_prefix;
               if (int'(req_chan.bit_count) > ADDR_BITS) begin
                  rem_in = CW'(ADDR_BITS);
               end else begin
                  rem_in = CW'(req_chan.bit_count);
               end
               node_in  = '0;
               zero_in  = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            res_match_in  = 1'b0;
            res_status_in = STATUS_OK;
            if (cmd_ff == CMD_LOOKUP) begin
               // lookup: any subnet on the path, else exact end of full path
               if (word[SUBNET_B]) begin
                  res_match_in = 1'b1;
                  state_in     = S_FIN;
               end else if (rem_ff == '0) begin
                  res_match_in = word[EXACT_B];
                  state_in     = S_FIN;
               end else if (child == '0) begin
                  state_in = S_FIN;
               end else begin
                  node_in  = child;
                  rem_in   = rem_ff - CW'(1);
                  addr_in  = addr_ff << 1;
                  zero_in  = 1'b0;
                  state_in = S_RD;
               end
            end else begin
               // insert: mark the final node, or descend, or allocate, or report full
               if (rem_ff == '0) begin
                  upd[EXACT_B]  = 1'b1;
                  upd[SUBNET_B] = word[SUBNET_B] | pre_ff;
                  mem_wr_en     = 1'b1;
                  mem_wr_data   = upd;
                  state_in      = S_FIN;
               end else if (child != '0) begin
                  node_in  = child;
                  rem_in   = rem_ff - CW'(1);
                  addr_in  = addr_ff << 1;
                  zero_in  = 1'b0;
                  state_in = S_RD;
               end else if (nf_ff == NW'(NODES)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_FIN;
               end else begin
                  if (bit_now) begin
                     upd[C1_LO +: IW] = nf_ff[IW-1:0];
                  end else begin
                     upd[C0_LO +: IW] = nf_ff[IW-1:0];
                  end
                  mem_wr_en   = 1'b1;
                  mem_wr_data = upd;
                  node_in     = nf_ff[IW-1:0];
                  nf_in       = nf_ff + NW'(1);
                  rem_in      = rem_ff - CW'(1);
                  addr_in     = addr_ff << 1;
                  state_in    = S_ZERO;
               end
            end
         end
         S_ZERO: begin
            // fresh node is written blank and evaluated without a read
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            zero_in     = 1'b1;
            state_in    = S_EVAL;
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register, loaded when the slot frees up
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_match_in  = rsp_match_ff;
      rsp_status_in = rsp_status_ff;
      if ((state_ff == S_FIN) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_match_in  = res_match_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nf_ff        <= NW'(1);
         rsp_valid_ff <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
         zero_ff      <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      pre_ff        <= pre_in;
      rem_ff        <= rem_in;
      node_ff       <= node_in;
      res_match_ff  <= res_match_in;
      res_status_ff <= res_status_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.match  = rsp_match_ff;
   assign rsp_chan.status = rsp_status_ff;

   // checks
   `ASSERT_ALWAYS(a_nf_range, (reset || ((nf_ff >= NW'(1)) && (nf_ff <= NW'(NODES)))), "free pointer out of range")
   `ASSERT_CLK(a_wr_allocated, mem_wr_en |-> (NW'(mem_wr_addr) < nf_in), "write to an unallocated node")
   `ASSERT_CLK(a_end_of_walk, (state_ff == S_EVAL && rem_ff == '0) |=> (state_ff == S_FIN), "walk continued past its last bit")
   `ASSERT_CLK(a_zero_then_eval, (state_ff == S_ZERO) |=> (state_ff == S_EVAL && zero_ff), "fresh node not evaluated as blank")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for binary_trie_prefix_match: random and directed lookups and inserts
// depends on btpm_pkg, btpm_if and the rtl top; a behavioral trie predicts every response

module tb_top;
   import btpm_pkg::*;

   localparam int ADDR_W       = ADDR_BITS_DEF;
   localparam int POOL_SIZE    = NODES_DEF;
   localparam int RANDOM_ITEMS = 1000;
   localparam int FILL_ITEMS   = 200;
   localparam int DRAIN_CYCLES = 150;
   localparam int LIMIT_CYCLES = 1000000;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] address;
      logic [CNT_W-1:0]  bit_count;
      logic              is_prefix;
   } trie_req_type;

   typedef struct packed {
      logic match;
      logic status;
   } trie_rsp_type;

   typedef struct packed {
      trie_req_type req;
      trie_rsp_type rsp;
   } lookup_outcome_type;

   logic clock;
   logic reset;

   btpm_req_if #(.ADDR_BITS(ADDR_W)) req_if ();
   btpm_rsp_if rsp_if ();

   binary_trie_prefix_match #(
      .NODES     (POOL_SIZE),
      .ADDR_BITS (ADDR_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow trie state
   logic [11:0] trie_zero   [POOL_SIZE] = '{default: '0};
   logic [11:0] trie_one    [POOL_SIZE] = '{default: '0};
   logic        trie_subnet [POOL_SIZE] = '{default: 1'b0};
   logic        trie_exact  [POOL_SIZE] = '{default: 1'b0};
   int unsigned pool_next = 1;

   trie_req_type       pending_q [$];
   lookup_outcome_type outcome_q [$];
   logic [ADDR_W-1:0]  entry_addr [$];
   logic [CNT_W-1:0]   entry_cnt [$];
   logic [ADDR_W-1:0]  region_base [8];

   int  mismatch_cnt;
   int  cycle_cnt;
   int  lookup_cnt, insert_cnt, hit_cnt, full_cnt;
   bit  req_taken, rsp_taken;
   bit  req_quiet, rsp_quiet;
   int  req_wait, rsp_stall;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one beat to the shadow trie and returns the response it should give
   function automatic trie_rsp_type trie_outcome(trie_req_type it);
      trie_rsp_type r;
      int           walk_len;
      int unsigned  node, nxt, lvl;
      logic         b;
      r.match    = 1'b0;
      r.status   = STATUS_OK;
      walk_len   = (int'(it.bit_count) > ADDR_W) ? ADDR_W : int'(it.bit_count);
      node       = 0;
      if (it.cmd == CMD_LOOKUP) begin
         if (trie_subnet[0]) begin
            r.match = 1'b1;
            return r;
         end
         for (lvl = 0; lvl < walk_len; lvl++) begin
            b   = it.address[ADDR_W-1-lvl];
            nxt = b ? 32'(trie_one[node]) : 32'(trie_zero[node]);
            if (nxt == 0) return r;
            node = nxt;
            if (trie_subnet[node]) begin
               r.match = 1'b1;
               return r;
            end
         end
         r.match = trie_exact[node];
         return r;
      end
      // insert: allocate missing nodes along the path
      for (lvl = 0; lvl < walk_len; lvl++) begin
         b   = it.address[ADDR_W-1-lvl];
         nxt = b ? 32'(trie_one[node]) : 32'(trie_zero[node]);
         if (nxt == 0) begin
            if (pool_next >= POOL_SIZE) begin
               r.status = STATUS_FULL;
               return r;
            end
            nxt = pool_next;
            pool_next++;
            trie_zero[nxt]   = '0;
            trie_one[nxt]    = '0;
            trie_subnet[nxt] = 1'b0;
            trie_exact[nxt]  = 1'b0;
            if (b) trie_one[node] = nxt[11:0];
            else trie_zero[node] = nxt[11:0];
         end
         node = nxt;
      end
      trie_exact[node] = 1'b1;
      if (it.is_prefix) trie_subnet[node] = 1'b1;
      return r;
   endfunction

   task automatic log_mismatch(string msg);
      mismatch_cnt++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic push_item(logic cmd, logic [ADDR_W-1:0] a, int cnt, logic pre);
      trie_req_type it;
      it.cmd       = cmd;
      it.address   = a;
      it.bit_count = cnt[CNT_W-1:0];
      it.is_prefix = pre;
      if (cmd == CMD_INSERT) begin
         entry_addr = {entry_addr, a};
         entry_cnt  = {entry_cnt, cnt[CNT_W-1:0]};
      end
      pending_q = {pending_q, it};
   endtask

   // mostly addresses that share leading bits with a few regions, so paths overlap
   task automatic push_random_item();
      int unsigned       pick, share, k, flip;
      logic [ADDR_W-1:0] keep_mask, a;
      int                cnt;
      logic              cmd, pre;
      pick      = $urandom_range(0, 99);
      share     = $urandom_range(8, 24);
      keep_mask = ~({ADDR_W{1'b1}} >> share);
      a         = (region_base[$urandom_range(0, 7)] & keep_mask) | ($urandom() & ~keep_mask);
      cnt       = $urandom_range(0, 32);
      cmd       = CMD_LOOKUP;
      pre       = 1'($urandom_range(0, 1));
      if (pick < 30) begin
         cmd = CMD_INSERT;
         cnt = $urandom_range(share, 32);
         pre = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) cnt = $urandom_range(6, 63);
      end else if (pick < 55 && entry_addr.size() > 0) begin
         // revisit a stored entry, sometimes one bit or the length off
         k    = $urandom_range(0, entry_addr.size() - 1);
         a    = entry_addr[k];
         cnt  = int'(entry_cnt[k]);
         flip = $urandom_range(0, 3);
         if (flip == 1) a[$urandom_range(0, ADDR_W-1)] ^= 1'b1;
         else if (flip == 2) cnt = $urandom_range(0, 63);
      end else if (pick >= 90) begin
         a   = $urandom();
         cnt = $urandom_range(0, 63);
      end
      push_item(cmd, a, cnt, pre);
   endtask

   // waits until every beat is sent and every response is back
   task automatic drain_outstanding();
      while (pending_q.size() != 0 || req_if.valid || outcome_q.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      trie_req_type it;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // hold the beat until it is taken
      end else if (req_wait > 0) begin
         req_wait--;
         req_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
         it = pending_q.pop_front();
         req_if.cmd       <= it.cmd;
         req_if.address   <= it.address;
         req_if.bit_count <= it.bit_count;
         req_if.is_prefix <= it.is_prefix;
         req_if.valid     <= 1'b1;
         if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
         req_wait = req_quiet ? 0 : $urandom_range(0, 12);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // response sink with random back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
            rsp_stall = rsp_quiet ? 0 : $urandom_range(0, 12);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // monitor: predict on each request beat, check each response beat
   always @(posedge clock) begin
      lookup_outcome_type o;
      trie_req_type       it;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken    = 1'b1;
            it.cmd       = req_if.cmd;
            it.address   = req_if.address;
            it.bit_count = req_if.bit_count;
            it.is_prefix = req_if.is_prefix;
            o.req        = it;
            o.rsp        = trie_outcome(it);
            outcome_q    = {outcome_q, o};
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken = 1'b1;
            if (outcome_q.size() == 0) begin
               log_mismatch($sformatf("response beat with none outstanding: match=%0b status=%0b",
                                      rsp_if.match, rsp_if.status));
            end else begin
               o = outcome_q.pop_front();
               if (o.req.cmd == CMD_LOOKUP) lookup_cnt++;
               else insert_cnt++;
               if (o.rsp.match) hit_cnt++;
               if (o.rsp.status == STATUS_FULL) full_cnt++;
               if (rsp_if.match !== o.rsp.match)
                  log_mismatch($sformatf("cmd=%0b addr=%h cnt=%0d pre=%0b: match %b, want %b",
                                         o.req.cmd, o.req.address, o.req.bit_count,
                                         o.req.is_prefix, rsp_if.match, o.rsp.match));
               if (rsp_if.status !== o.rsp.status)
                  log_mismatch($sformatf("cmd=%0b addr=%h cnt=%0d pre=%0b: status %b, want %b",
                                         o.req.cmd, o.req.address, o.req.bit_count,
                                         o.req.is_prefix, rsp_if.status, o.rsp.status));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
                  outcome_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      int i;
      logic [ADDR_W-1:0] a;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_LOOKUP;
      req_if.address   = '0;
      req_if.bit_count = '0;
      req_if.is_prefix = 1'b0;
      rsp_if.ready     = 1'b0;
      for (i = 0; i < 8; i++) region_base[i] = $urandom();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty trie, root marks, full-length paths, clamped length, prefixes
      push_item(CMD_LOOKUP, 32'h0000_0000, 0,  1'b0);
      push_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32, 1'b0);
      push_item(CMD_LOOKUP, 32'h1234_5678, 63, 1'b1);
      push_item(CMD_INSERT, 32'h0000_0000, 0,  1'b0);
      push_item(CMD_LOOKUP, 32'hDEAD_BEEF, 0,  1'b0);
      push_item(CMD_LOOKUP, 32'hDEAD_BEEF, 5,  1'b0);
      push_item(CMD_INSERT, 32'hFFFF_FFFF, 32, 1'b0);
      push_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32, 1'b0);
      push_item(CMD_LOOKUP, 32'hFFFF_FFFF, 31, 1'b0);
      push_item(CMD_LOOKUP, 32'hFFFF_FFFE, 32, 1'b0);
      push_item(CMD_INSERT, 32'h0000_0000, 63, 1'b0);
      push_item(CMD_LOOKUP, 32'h0000_0000, 32, 1'b0);
      push_item(CMD_LOOKUP, 32'h0000_0000, 40, 1'b0);
      push_item(CMD_INSERT, 32'hA000_0000, 4,  1'b1);
      push_item(CMD_LOOKUP, 32'hAFFF_FFFF, 32, 1'b0);
      push_item(CMD_LOOKUP, 32'hA555_5555, 3,  1'b0);
      push_item(CMD_LOOKUP, 32'h8000_0000, 4,  1'b1);
      push_item(CMD_INSERT, 32'hA000_0000, 4,  1'b0);
      push_item(CMD_INSERT, 32'h7FFF_FFFF, 32, 1'b1);
      push_item(CMD_LOOKUP, 32'h7FFF_FFFF, 32, 1'b0);
      push_item(CMD_INSERT, 32'h5555_5555, 1,  1'b0);
      push_item(CMD_LOOKUP, 32'h0000_0000, 1,  1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) push_random_item();

      // let everything settle before exhausting the pool
      drain_outstanding();

      // unrelated full-length inserts until the pool runs out
      for (i = 0; i < FILL_ITEMS; i++) begin
         a = $urandom();
         push_item(CMD_INSERT, a, 32, 1'b0);
         if (i % 4 == 0) push_item(CMD_LOOKUP, a, $urandom_range(0, 63), 1'b0);
      end
      // with a full pool: existing paths still take marks, new ones report full
      for (i = 0; i < 5; i++) begin
         push_item(CMD_INSERT, entry_addr[i], int'(entry_cnt[i]), 1'b1);
         push_item(CMD_LOOKUP, entry_addr[i], 32, 1'b0);
         push_item(CMD_INSERT, $urandom(), 32, 1'($urandom_range(0, 1)));
      end
      // a subnet at the root covers everything
      push_item(CMD_INSERT, $urandom(), 0, 1'b1);
      for (i = 0; i < 10; i++) push_item(CMD_LOOKUP, $urandom(), $urandom_range(0, 63), 1'b0);

      drain_outstanding();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run: %0d lookups (%0d matched), %0d inserts (%0d with a full pool)",
               lookup_cnt, hit_cnt, insert_cnt, full_cnt);
      $display("trie used %0d of %0d nodes, %0d mismatches", pool_next, POOL_SIZE, mismatch_cnt);
      if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/btpm_pkg.sv
rtl/core/btpm_if.sv
rtl/core/btpm_node_mem.sv
rtl/core/binary_trie_prefix_match.sv
verif/tb_top.sv
